// File: sv/iee_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iee_pkg
// Shared types and constants of the infix expression evaluator: character
// codes, token kinds, status codes and the control structs between modules.
// ----------------------------------------------------------------------------
package iee_pkg;

    // width of the result port
    localparam int OUT_WIDTH = 32;

    // token queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    // ascii codes
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_EQUAL = 8'h3D;

    // result status codes
    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_DIV0 = 2'd1;
    localparam logic [1:0] STATUS_BAD  = 2'd2;

    // classified character
    typedef enum logic [2:0] {
        TOK_DIGIT = 3'd0,
        TOK_MUL   = 3'd1,
        TOK_DIV   = 3'd2,
        TOK_ADD   = 3'd3,
        TOK_SUB   = 3'd4,
        TOK_EQ    = 3'd5,
        TOK_BAD   = 3'd6
    } tok_kind_t;

    typedef struct packed {
        tok_kind_t  kind;
        logic [3:0] digit;
    } tok_t;

    // front to queue write request
    typedef struct packed {
        logic valid;
        tok_t tok;
    } tok_push_t;

    // pending multiplicative operator
    typedef enum logic [1:0] {
        POP_NONE = 2'd0,
        POP_MUL  = 2'd1,
        POP_DIV  = 2'd2
    } prod_op_t;

    // arithmetic unit operation
    typedef enum logic {
        MD_MUL = 1'b0,
        MD_DIV = 1'b1
    } md_op_t;

    typedef struct packed {
        logic   start;
        md_op_t op;
    } md_req_t;

    typedef struct packed {
        logic busy;
        logic div0;
    } md_rsp_t;

endpackage

// File: sv/iee_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iee_front
// Input side: takes one character per request, drops spaces and turns the
// rest into tokens written to the queue.
// ----------------------------------------------------------------------------
module iee_front (
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_char_code,
    input  logic              queue_full,
    output iee_pkg::tok_push_t push
);
    import iee_pkg::*;

    // character classification
    function automatic tok_t classify(input logic [7:0] c);
        tok_t t;
        t.digit = 4'(c - CHAR_ZERO);
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            t.kind = TOK_DIGIT;
        end else begin
            case (c)
                CHAR_STAR:  t.kind = TOK_MUL;
                CHAR_SLASH: t.kind = TOK_DIV;
                CHAR_PLUS:  t.kind = TOK_ADD;
                CHAR_MINUS: t.kind = TOK_SUB;
                CHAR_EQUAL: t.kind = TOK_EQ;
                default:    t.kind = TOK_BAD;
            endcase
        end
        return t;
    endfunction

    // accept whenever the queue has room, spaces are consumed here
    assign s_ready    = !queue_full;
    assign push.valid = s_valid && !queue_full && (s_char_code != CHAR_SPACE);
    assign push.tok   = classify(s_char_code);

endmodule

// File: sv/iee_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iee_fifo
// Small token queue that decouples character intake from evaluation.
// ----------------------------------------------------------------------------
module iee_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  iee_pkg::tok_push_t push,
    output logic               full,
    output logic               head_valid,
    output iee_pkg::tok_t      head_tok,
    input  logic               pop
);
    import iee_pkg::*;

    tok_t                   slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_PTR_W:0]   count_reg, count_next;
    logic                   do_push, do_pop;

    assign full       = (count_reg == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_tok   = slot_reg[rd_ptr_reg];

    assign do_push = push.valid && !full;
    assign do_pop  = pop && head_valid;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // token storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push.tok;
        end
    end

endmodule

// File: sv/iee_muldiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iee_muldiv
// Shared iterative unit: shift-add multiply (low half of the product) and
// restoring signed divide truncating toward zero, one bit per cycle.
// ----------------------------------------------------------------------------
module iee_muldiv #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  iee_pkg::md_req_t       req,
    input  logic [VALUE_WIDTH-1:0] a,
    input  logic [VALUE_WIDTH-1:0] b,
    output iee_pkg::md_rsp_t       rsp,
    output logic [VALUE_WIDTH-1:0] result
);
    import iee_pkg::*;

    localparam int CW = $clog2(VALUE_WIDTH);

    typedef enum logic [2:0] {
        MD_IDLE = 3'b001,
        MD_RUN  = 3'b010,
        MD_FIX  = 3'b100
    } md_state_t;

    md_state_t              state_reg, state_next;
    md_op_t                 op_reg, op_next;
    logic [VALUE_WIDTH-1:0] x_reg, x_next;
    logic [VALUE_WIDTH-1:0] y_reg, y_next;
    logic [VALUE_WIDTH-1:0] r_reg, r_next;
    logic [VALUE_WIDTH-1:0] res_reg, res_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   neg_reg, neg_next;
    logic                   div0_reg, div0_next;
    logic [VALUE_WIDTH-1:0] a_mag, b_mag;
    logic [VALUE_WIDTH:0]   rem_shift, rem_diff;

    assign a_mag = a[VALUE_WIDTH-1] ? (~a + 1'b1) : a;
    assign b_mag = b[VALUE_WIDTH-1] ? (~b + 1'b1) : b;

    // restoring divide step
    assign rem_shift = {r_reg, x_reg[VALUE_WIDTH-1]};
    assign rem_diff  = rem_shift - {1'b0, y_reg};

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        r_next     = r_reg;
        res_next   = res_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        div0_next  = div0_reg;
        case (state_reg)
            MD_IDLE: begin
                if (req.start) begin
                    op_next   = req.op;
                    cnt_next  = CW'(VALUE_WIDTH - 1);
                    r_next    = '0;
                    div0_next = 1'b0;
                    neg_next  = a[VALUE_WIDTH-1] ^ b[VALUE_WIDTH-1];
                    if (req.op == MD_DIV) begin
                        x_next = a_mag;
                        y_next = b_mag;
                        if (b == '0) begin
                            // zero divisor: quotient 0, flag it
                            res_next  = '0;
                            div0_next = 1'b1;
                        end else begin
                            state_next = MD_RUN;
                        end
                    end else begin
                        x_next     = a;
                        y_next     = b;
                        state_next = MD_RUN;
                    end
                end
            end
            MD_RUN: begin
                if (op_reg == MD_DIV) begin
                    if (!rem_diff[VALUE_WIDTH]) begin
                        r_next = rem_diff[VALUE_WIDTH-1:0];
                    end else begin
                        r_next = rem_shift[VALUE_WIDTH-1:0];
                    end
                    x_next = {x_reg[VALUE_WIDTH-2:0], !rem_diff[VALUE_WIDTH]};
                end else begin
                    if (y_reg[0]) begin
                        r_next = r_reg + x_reg;
                    end
                    x_next = {x_reg[VALUE_WIDTH-2:0], 1'b0};
                    y_next = {1'b0, y_reg[VALUE_WIDTH-1:1]};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = MD_FIX;
                end
            end
            MD_FIX: begin
                // sign fix of the quotient; the product passes through as is
                if (op_reg == MD_DIV) begin
                    res_next = neg_reg ? (~x_reg + 1'b1) : x_reg;
                end else begin
                    res_next = r_reg;
                end
                state_next = MD_IDLE;
            end
            default: begin
                state_next = MD_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MD_IDLE;
            div0_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            div0_reg  <= div0_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg  <= op_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        r_reg   <= r_next;
        res_reg <= res_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
    end

    assign rsp.busy = (state_reg != MD_IDLE);
    assign rsp.div0 = div0_reg;
    assign result   = res_reg;

endmodule

// File: sv/iee_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iee_back
// Evaluation side: pops tokens, keeps the number, product term and sum,
// runs pending * and / through the shared unit and registers each result.
// ----------------------------------------------------------------------------
module iee_back #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                head_valid,
    input  iee_pkg::tok_t                       head_tok,
    output logic                                pop,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [iee_pkg::OUT_WIDTH-1:0] m_value,
    output logic [1:0]                          m_status
);
    import iee_pkg::*;

    typedef enum logic [1:0] {
        BK_IDLE = 2'b01,
        BK_WAIT = 2'b10
    } bk_state_t;

    bk_state_t              state_reg, state_next;
    tok_kind_t              pend_reg, pend_next;
    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;
    logic                   minus_reg, minus_next;
    logic [VALUE_WIDTH-1:0] term_reg, term_next;
    prod_op_t               pop_reg, pop_next;
    logic [VALUE_WIDTH-1:0] num_reg, num_next;
    logic [1:0]             err_reg, err_next;
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_WIDTH-1:0]   value_reg, value_next;
    logic [1:0]             status_reg, status_next;

    md_req_t                md_req;
    md_rsp_t                md_rsp;
    logic [VALUE_WIDTH-1:0] md_result;

    logic                   out_busy;
    logic                   fin_en;
    tok_kind_t              fin_kind;
    logic [VALUE_WIDTH-1:0] fin_term;
    logic [1:0]             fin_err;
    logic [VALUE_WIDTH-1:0] fin_sum;
    logic [OUT_WIDTH-1:0]   fin_sum_ext;
    logic [VALUE_WIDTH-1:0] num_times_ten;

    iee_muldiv #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_muldiv (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (md_req),
        .a      (term_reg),
        .b      (num_reg),
        .rsp    (md_rsp),
        .result (md_result)
    );

    assign out_busy = out_valid_reg && !m_ready;

    // next decimal digit
    assign num_times_ten = {num_reg[VALUE_WIDTH-4:0], 3'b000}
                         + {num_reg[VALUE_WIDTH-2:0], 1'b0}
                         + {{(VALUE_WIDTH-4){1'b0}}, head_tok.digit};

    // additive fold of the closed term
    assign fin_sum = minus_reg ? (acc_reg - fin_term) : (acc_reg + fin_term);

    generate
        if (VALUE_WIDTH >= OUT_WIDTH) begin : g_trunc
            assign fin_sum_ext = fin_sum[OUT_WIDTH-1:0];
        end else begin : g_sext
            assign fin_sum_ext = {{(OUT_WIDTH-VALUE_WIDTH){fin_sum[VALUE_WIDTH-1]}}, fin_sum};
        end
    endgenerate

    always_comb begin
        state_next     = state_reg;
        pend_next      = pend_reg;
        acc_next       = acc_reg;
        minus_next     = minus_reg;
        term_next      = term_reg;
        pop_next       = pop_reg;
        num_next       = num_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg && !m_ready;
        value_next     = value_reg;
        status_next    = status_reg;
        pop            = 1'b0;
        md_req.start   = 1'b0;
        md_req.op      = (pop_reg == POP_DIV) ? MD_DIV : MD_MUL;
        fin_en         = 1'b0;
        fin_kind       = head_tok.kind;
        fin_term       = num_reg;
        fin_err        = err_reg;

        // token dispatch and arithmetic unit handoff
        case (state_reg)
            BK_IDLE: begin
                if (head_valid) begin
                    case (head_tok.kind)
                        TOK_DIGIT: begin
                            pop      = 1'b1;
                            num_next = num_times_ten;
                        end
                        TOK_MUL, TOK_DIV, TOK_ADD, TOK_SUB, TOK_EQ: begin
                            if (!(head_tok.kind == TOK_EQ && out_busy)) begin
                                pop = 1'b1;
                                if (pop_reg == POP_NONE) begin
                                    fin_en = 1'b1;
                                end else begin
                                    md_req.start = 1'b1;
                                    num_next     = '0;
                                    pend_next    = head_tok.kind;
                                    state_next   = BK_WAIT;
                                end
                            end
                        end
                        default: begin
                            // malformed character
                            pop = 1'b1;
                            if (err_reg == STATUS_OK) begin
                                err_next = STATUS_BAD;
                            end
                        end
                    endcase
                end
            end
            BK_WAIT: begin
                fin_kind = pend_reg;
                fin_term = md_result;
                if (md_rsp.div0 && err_reg == STATUS_OK) begin
                    fin_err = STATUS_DIV0;
                end
                if (!md_rsp.busy && !(pend_reg == TOK_EQ && out_busy)) begin
                    fin_en     = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase

        // apply the operator once its left term is closed
        if (fin_en) begin
            num_next = '0;
            err_next = fin_err;
            case (fin_kind)
                TOK_MUL: begin
                    term_next = fin_term;
                    pop_next  = POP_MUL;
                end
                TOK_DIV: begin
                    term_next = fin_term;
                    pop_next  = POP_DIV;
                end
                TOK_ADD, TOK_SUB: begin
                    acc_next   = fin_sum;
                    term_next  = '0;
                    pop_next   = POP_NONE;
                    minus_next = (fin_kind == TOK_SUB);
                end
                TOK_EQ: begin
                    out_valid_next = 1'b1;
                    value_next     = fin_sum_ext;
                    status_next    = fin_err;
                    acc_next       = '0;
                    minus_next     = 1'b0;
                    term_next      = '0;
                    pop_next       = POP_NONE;
                    err_next       = STATUS_OK;
                end
                default: begin
                    term_next = term_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            acc_reg       <= '0;
            minus_reg     <= 1'b0;
            term_reg      <= '0;
            pop_reg       <= POP_NONE;
            num_reg       <= '0;
            err_reg       <= STATUS_OK;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            minus_reg     <= minus_next;
            term_reg      <= term_next;
            pop_reg       <= pop_next;
            num_reg       <= num_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg   <= pend_next;
        value_reg  <= value_next;
        status_reg <= status_next;
    end

    assign m_valid  = out_valid_reg;
    assign m_value  = value_reg;
    assign m_status = status_reg;

endmodule

// File: sv/infix_expression_evaluator_unit.sv
// Result path: a '=' with no pending * or / passes the token queue and is then registered as the result.
// Throughput: one character per cycle while the token queue has room; an operator
//   or '=' that closes a pending * or / holds the back end until the shared
//   one-bit-per-cycle arithmetic unit has finished.
// Reset: synchronous, active low; clears the queue, the expression state and the
//   output valid; no clearing pass.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_expression_evaluator_unit
// Character-serial evaluator of + - * / integer expressions ended by '='.
// ----------------------------------------------------------------------------
module infix_expression_evaluator_unit #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [7:0]                           s_char_code,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [iee_pkg::OUT_WIDTH-1:0] m_value,
    output logic [1:0]                           m_status
);
    import iee_pkg::*;

    tok_push_t push;
    logic      queue_full;
    logic      head_valid;
    tok_t      head_tok;
    logic      pop;

    // character intake and classification
    iee_front u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_char_code(s_char_code),
        .queue_full (queue_full),
        .push       (push)
    );

    // token queue
    iee_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .full      (queue_full),
        .head_valid(head_valid),
        .head_tok  (head_tok),
        .pop       (pop)
    );

    // evaluation and result register
    iee_back #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_valid(head_valid),
        .head_tok  (head_tok),
        .pop       (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_value   (m_value),
        .m_status  (m_status)
    );

endmodule

// File: sv/iee_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iee_checker
// Port-level checks of the evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module iee_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [7:0]  s_char_code,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_value,
    input logic [1:0]  m_status
);

    // a stalled result request holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value) && $stable(m_status))
        else $error("result request changed while stalled");

    // reset drops any pending result
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // reset empties the queue so input is taken right away
    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("input not ready after reset");

    // a result taken while a '=' is offered reports a legal status code
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && s_valid && s_char_code == 8'h3D |-> m_status != 2'd3)
        else $error("illegal status code");

endmodule

bind infix_expression_evaluator_unit iee_checker u_iee_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .s_char_code(s_char_code),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_value    (m_value),
    .m_status   (m_status)
);
